FILE: hw/rtl/tgsa_pkg.sv
// ----------------------------------------------------------------------------
// tgsa_pkg
// shared types, sizes and codes of the gather / scatter-add block
// ----------------------------------------------------------------------------
package tgsa_pkg;

	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int INDEX_SLOTS = 64;
	localparam int DATA_W      = 32;
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int SLOT_W      = $clog2(INDEX_SLOTS);
	localparam int PADDR_W     = 4;

	// action codes
	localparam logic [2:0] ACT_WRITE_VALUE = 3'd0;
	localparam logic [2:0] ACT_WRITE_INDEX = 3'd1;
	localparam logic [2:0] ACT_GATHER      = 3'd2;
	localparam logic [2:0] ACT_SCATTER     = 3'd3;
	localparam logic [2:0] ACT_READ_CLEAR  = 3'd4;

	// register indexes (word address)
	localparam logic [1:0] REG_ALONG_ROWS = 2'd0;
	localparam logic [1:0] REG_VALUE_ROWS = 2'd1;
	localparam logic [1:0] REG_VALUE_COLS = 2'd2;

	typedef struct packed {
		logic [2:0]               action;
		logic [5:0]               row;
		logic [5:0]               col;
		logic signed [DATA_W-1:0] data;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result;
		logic                     in_bounds;
	} rsp_t;

	typedef struct packed {
		logic       along_rows;
		logic [6:0] value_rows;
		logic [6:0] value_cols;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic idx_rd;
		logic locate;
		logic mem_rd;
		logic exe;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic       clr_last;
		logic       rsp_free;
	} stat_t;

endpackage

FILE: hw/rtl/tgsa_regs.sv
// ----------------------------------------------------------------------------
// tgsa_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module tgsa_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tgsa_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output tgsa_pkg::cfg_t                cfg
);
	import tgsa_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.along_rows <= 1'b0;
			cfg_q.value_rows <= 7'd1;
			cfg_q.value_cols <= 7'd64;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_ALONG_ROWS: cfg_q.along_rows <= pwdata[0];
				REG_VALUE_ROWS: cfg_q.value_rows <= pwdata[6:0];
				REG_VALUE_COLS: cfg_q.value_cols <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ALONG_ROWS: prdata = {31'd0, cfg_q.along_rows};
			REG_VALUE_ROWS: prdata = {25'd0, cfg_q.value_rows};
			REG_VALUE_COLS: prdata = {25'd0, cfg_q.value_cols};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

FILE: hw/rtl/tgsa_ctrl.sv
// ----------------------------------------------------------------------------
// tgsa_ctrl
// sequencer: clearing pass, then one transaction at a time through the datapath
// ----------------------------------------------------------------------------
module tgsa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tgsa_pkg::stat_t stat,
	output tgsa_pkg::cmd_t  cmd
);
	import tgsa_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_IDX,
		S_LOC,
		S_RD,
		S_EXE
	} state_t;

	state_t state_q;
	logic   has_result;
	logic   exe_go;

	assign has_result = (stat.action == ACT_GATHER) || (stat.action == ACT_READ_CLEAR);
	// a result-producing action waits here until the output slot is free
	assign exe_go     = (state_q == S_EXE) && (!has_result || stat.rsp_free);

	assign req_ready  = (state_q == S_IDLE);
	assign cmd.load   = req_valid && (state_q == S_IDLE);
	assign cmd.idx_rd = (state_q == S_IDX);
	assign cmd.locate = (state_q == S_LOC);
	assign cmd.mem_rd = (state_q == S_RD);
	assign cmd.exe    = exe_go;
	assign cmd.clr    = (state_q == S_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: if (stat.clr_last) state_q <= S_IDLE;
				S_IDLE:  if (req_valid) state_q <= S_IDX;
				S_IDX:   state_q <= S_LOC;
				S_LOC:   state_q <= S_RD;
				S_RD:    state_q <= S_EXE;
				S_EXE:   if (exe_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/tgsa_dp.sv
// ----------------------------------------------------------------------------
// tgsa_dp
// datapath: item register, index / value / gradient memories, locate, output
// ----------------------------------------------------------------------------
module tgsa_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  tgsa_pkg::cfg_t  cfg,
	input  tgsa_pkg::cmd_t  cmd,
	output tgsa_pkg::stat_t stat,
	input  tgsa_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output tgsa_pkg::rsp_t  rsp
);
	import tgsa_pkg::*;

	logic [DATA_W-1:0] index_mem [INDEX_SLOTS];
	logic [DATA_W-1:0] value_mem [STORE_DEPTH];
	logic [DATA_W-1:0] grad_mem  [STORE_DEPTH];

	req_t              item_q;
	logic [DATA_W-1:0] idx_q;
	logic [ADDR_W-1:0] pos_q;
	logic              ok_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] grad_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [SLOT_W-1:0] rd_slot;
	logic [31:0]       ind;
	logic [31:0]       bound;
	logic [31:0]       r_sel;
	logic [31:0]       c_sel;
	logic [31:0]       pos_full;
	logic              ok_next;
	logic              by_index;
	logic              has_result;
	logic              idx_we;
	logic              val_we;
	logic              grad_we;
	logic [ADDR_W-1:0] grad_waddr;
	logic [DATA_W-1:0] grad_wdata;
	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] sat_sum;

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= req;
	end

	// locate
	assign rd_slot  = cfg.along_rows ? item_q.row[SLOT_W-1:0] : item_q.col[SLOT_W-1:0];
	assign by_index = (item_q.action == ACT_GATHER) || (item_q.action == ACT_SCATTER);
	assign ind      = 32'(idx_q[31:16]);

	always_comb begin
		if (cfg.along_rows) begin
			bound = (32'(cfg.value_rows) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(cfg.value_rows);
		end else begin
			bound = (32'(cfg.value_cols) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(cfg.value_cols);
		end
		if (by_index && cfg.along_rows) begin
			r_sel = ind;
			c_sel = 32'(item_q.col);
		end else if (by_index) begin
			r_sel = 32'(item_q.row);
			c_sel = ind;
		end else begin
			r_sel = 32'(item_q.row);
			c_sel = 32'(item_q.col);
		end
		ok_next = (r_sel < 32'(MAX_ROWS)) && (c_sel < 32'(MAX_COLS));
		if (by_index) begin
			ok_next = ok_next && !idx_q[31] && (ind < bound);
		end
		pos_full = r_sel * 32'(MAX_COLS) + c_sel;
	end

	always_ff @(posedge clk) begin
		if (cmd.locate) begin
			pos_q <= ADDR_W'(pos_full);
			ok_q  <= ok_next;
		end
	end

	// saturating accumulate
	assign sum     = {grad_q[DATA_W-1], grad_q} + {item_q.data[DATA_W-1], item_q.data};
	assign sat_sum = (sum[DATA_W] != sum[DATA_W-1])
		? (sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}})
		: sum[DATA_W-1:0];

	assign idx_we     = cmd.exe && (item_q.action == ACT_WRITE_INDEX);
	assign val_we     = cmd.exe && ok_q && (item_q.action == ACT_WRITE_VALUE);
	assign grad_we    = cmd.clr || (cmd.exe && ok_q &&
		((item_q.action == ACT_SCATTER) || (item_q.action == ACT_READ_CLEAR)));
	assign grad_waddr = cmd.clr ? clr_addr_q : pos_q;
	assign grad_wdata = (!cmd.clr && (item_q.action == ACT_SCATTER)) ? sat_sum : '0;

	always_ff @(posedge clk) begin
		if (idx_we) index_mem[item_q.col[SLOT_W-1:0]] <= item_q.data;
		if (cmd.idx_rd) idx_q <= index_mem[rd_slot];
	end

	always_ff @(posedge clk) begin
		if (val_we) value_mem[pos_q] <= item_q.data;
		if (cmd.mem_rd) val_q <= value_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (grad_we) grad_mem[grad_waddr] <= grad_wdata;
		if (cmd.mem_rd) grad_q <= grad_mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	// output register
	assign has_result = (item_q.action == ACT_GATHER) || (item_q.action == ACT_READ_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.exe && has_result) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exe && has_result) begin
			rsp_q.in_bounds <= ok_q;
			if (!ok_q) begin
				rsp_q.result <= '0;
			end else if (item_q.action == ACT_GATHER) begin
				rsp_q.result <= val_q;
			end else begin
				rsp_q.result <= grad_q;
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;
	assign stat.action   = item_q.action;
	assign stat.clr_last = (clr_addr_q == ADDR_W'(STORE_DEPTH - 1));
	assign stat.rsp_free = !rsp_valid_q || rsp_ready;

endmodule

FILE: hw/rtl/tensor_gather_scatter_add_top.sv
// ----------------------------------------------------------------------------
// tensor_gather_scatter_add_top
// gather / scatter-add engine for one sample column with q16.16 indices
// ----------------------------------------------------------------------------
// After reset the block sweeps the 4096-entry gradient memory to zero, one
// entry per cycle, and req_ready stays low until the sweep ends (register
// writes are taken during the sweep). Each transaction then runs these steps
// from acceptance until req_ready is high again: acceptance, index memory
// read, index floor and bound check, value or gradient memory read, and the
// execute cycle that writes memory or loads the result register. These five
// steps run in order, one item at a time.
// A gather or read-and-clear whose result register is still held by the
// consumer waits in the execute cycle; a finished result can sit in the
// output register while the next transaction is accepted. Value and index
// memories are not initialized: gathering from an entry never written gives
// an arbitrary word.
// ----------------------------------------------------------------------------
module tensor_gather_scatter_add_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tgsa_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// request channel
	input  logic                          req_valid,
	output logic                          req_ready,
	input  tgsa_pkg::req_t                req,
	// response channel
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output tgsa_pkg::rsp_t                rsp
);
	import tgsa_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	// register file
	tgsa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	tgsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// memories, locate and output register
	tgsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// no transaction is taken while the gradient sweep runs
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !req_ready)
		else $error("transaction accepted during gradient clear");

	// one transaction at a time: ready drops right after an acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second transaction accepted while one is in flight");

	// the gradient write port is never shared by the sweep and an execute step
	a_grad_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr && cmd.exe))
		else $error("gradient sweep collides with execute");

	// a result only loads when the output register can take it
	a_rsp_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exe && (stat.action == ACT_GATHER || stat.action == ACT_READ_CLEAR)
		|-> (!rsp_valid || rsp_ready))
		else $error("result overwrote a pending response");

endmodule
